// ----- hw/rtl/bptc_pkg.sv -----
// Shared types and constants for the barometric pressure/temperature compensation block.
// Depends on nothing; used by bptc_front, bptc_press and the top level.
package bptc_pkg;

  // Raw converter code width; both codes are masked to this many low bits
  localparam int ADC_WIDTH = 24;
  localparam logic [23:0] ADC_MASK = 24'((25'd1 << ADC_WIDTH) - 25'd1);

  localparam logic signed [18:0] TEMP_BASE = 19'sd2000;
  localparam logic signed [25:0] P_MAX = 26'sd4194303;
  localparam logic signed [25:0] P_MIN = -26'sd4194304;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } reg_idx_t;

  // Factory calibration words
  typedef struct packed {
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
    logic [15:0] c4;
    logic [15:0] c5;
    logic [15:0] c6;
  } calib_t;

  // Item handed from the temperature front end to the pressure back end
  typedef struct packed {
    logic [23:0]        d1;
    logic signed [24:0] dt;
    logic signed [18:0] temp;
    logic signed [37:0] off;
    logic signed [35:0] sens;
  } front_t;

  // Compensated result
  typedef struct packed {
    logic               clipped;
    logic signed [24:0] dt;
    logic signed [22:0] pressure;
    logic signed [18:0] temp;
  } result_t;

endpackage

// ----- hw/rtl/baro_temp_pressure_compensation.sv -----
// Top level of the first-order barometric compensation block: calibration
// registers, front end and pressure back end. Depends on bptc_pkg, bptc_front, bptc_press.
//
// Takes raw temperature (D2) and pressure (D1) codes and returns compensated
// temperature, pressure (saturated, with a clip flag) and dT. Six-stage pipeline:
// one item can be accepted in each cycle unless a held result has filled the
// pipeline. A stage holds when the output is not taken and the stage ahead is
// full, so bubbles are squeezed out under backpressure. The stages, in order, are
// dT, coefficient products, truncating divides, split D1*SENS product, merge and
// final divide with saturation. Calibration words must be written only while no item
// is in flight; the block does not enforce this. Writes to indexes above five are ignored.
module baro_temp_pressure_compensation import bptc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [23:0] temperature code D2, [47:24] pressure code D1
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [18:0] temperature, [41:19] pressure,
                                 // [66:42] temp_difference, [71:67] zero
  output logic        m_tuser,   // [0] pressure_clipped
  // calibration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  calib_t  cal;
  logic    mid_valid, mid_ready;
  front_t  mid_item;
  result_t res;

  // calibration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_C1:  cal.c1 <= cfg_data;
        REG_C2:  cal.c2 <= cfg_data;
        REG_C3:  cal.c3 <= cfg_data;
        REG_C4:  cal.c4 <= cfg_data;
        REG_C5:  cal.c5 <= cfg_data;
        REG_C6:  cal.c6 <= cfg_data;
        default: ;
      endcase
    end
  end

  bptc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cal        (cal),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .temp_code  (s_tdata[23:0]),
    .press_code (s_tdata[47:24]),
    .out_valid  (mid_valid),
    .out_ready  (mid_ready),
    .out_item   (mid_item)
  );

  bptc_press u_press (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_item   (mid_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (res)
  );

  // pack result item
  assign m_tdata = {5'b0, res.dt, res.pressure, res.temp};
  assign m_tuser = res.clipped;

  // input only stalls when the whole pipeline is full behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without output backpressure");

  // a clipped pressure sits exactly on a range limit
  a_clip_limit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |->
      (m_tdata[41:19] == 23'h3FFFFF || m_tdata[41:19] == 23'h400000))
    else $error("clip flag set on an unsaturated pressure");

  // a write to the reference temperature register lands
  a_cfg_c5: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == REG_C5) |=> (cal.c5 == $past(cfg_data)))
    else $error("reference temperature write lost");

endmodule

// ----- hw/rtl/bptc_front.sv -----
// Front end: dT, temperature, OFF and SENS in three register stages.
// Depends on bptc_pkg.
module bptc_front import bptc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  calib_t      cal,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] temp_code,
  input  logic [23:0] press_code,
  output logic        out_valid,
  input  logic        out_ready,
  output front_t      out_item
);

  logic v1, v2, v3;
  logic en1, en2, en3;

  // stage 1 registers
  logic [23:0]        s1_d1;
  logic signed [24:0] s1_dt;
  // stage 2 registers
  logic [23:0]        s2_d1;
  logic signed [24:0] s2_dt;
  logic signed [41:0] s2_pt, s2_po, s2_ps;
  // stage 3 registers
  front_t             s3;

  logic [23:0]        d2m;
  logic signed [24:0] dt_next;
  logic signed [41:0] pt_next, po_next, ps_next;
  logic signed [41:0] sh_t, sh_o, sh_s;
  logic signed [41:0] q_t, q_o, q_s;
  logic signed [41:0] off_w, sens_w;

  // stall chain: a stage loads when empty or when its successor moves
  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // stage 1: dT = D2 - C5*256
  always_comb begin
    d2m     = temp_code & ADC_MASK;
    dt_next = $signed({1'b0, d2m}) - $signed({1'b0, cal.c5, 8'b0});
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_d1 <= press_code & ADC_MASK;
      s1_dt <= dt_next;
    end
  end

  // stage 2: the three coefficient products
  always_comb begin
    pt_next = s1_dt * $signed({1'b0, cal.c6});
    po_next = s1_dt * $signed({1'b0, cal.c4});
    ps_next = s1_dt * $signed({1'b0, cal.c3});
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_d1 <= s1_d1;
      s2_dt <= s1_dt;
      s2_pt <= pt_next;
      s2_po <= po_next;
      s2_ps <= ps_next;
    end
  end

  // stage 3: divides truncate toward zero (floor plus one when negative with a remainder)
  always_comb begin
    sh_t   = s2_pt >>> 23;
    sh_o   = s2_po >>> 6;
    sh_s   = s2_ps >>> 7;
    q_t    = sh_t + {41'b0, s2_pt[41] && (|s2_pt[22:0])};
    q_o    = sh_o + {41'b0, s2_po[41] && (|s2_po[5:0])};
    q_s    = sh_s + {41'b0, s2_ps[41] && (|s2_ps[6:0])};
    off_w  = q_o + 42'($signed({1'b0, cal.c2, 17'b0}));
    sens_w = q_s + 42'($signed({1'b0, cal.c1, 16'b0}));
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3.d1   <= s2_d1;
      s3.dt   <= s2_dt;
      s3.temp <= 19'(q_t) + TEMP_BASE;
      s3.off  <= 38'(off_w);
      s3.sens <= 36'(sens_w);
    end
  end

  assign out_valid = v3;
  assign out_item  = s3;

endmodule

// ----- hw/rtl/bptc_press.sv -----
// Back end: P = (D1*SENS/2^21 - OFF)/2^15 with saturation, three register stages.
// Depends on bptc_pkg.
module bptc_press import bptc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  front_t  in_item,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_item
);

  logic v4, v5, v6;
  logic en4, en5, en6;

  // stage 4 registers: split product D1 * SENS
  logic [40:0]        s4_lo;
  logic signed [43:0] s4_hi;
  logic signed [37:0] s4_off;
  logic signed [24:0] s4_dt;
  logic signed [18:0] s4_temp;
  // stage 5 registers
  logic signed [39:0] s5_q;
  logic signed [37:0] s5_off;
  logic signed [24:0] s5_dt;
  logic signed [18:0] s5_temp;
  // stage 6 register
  result_t            s6;

  logic [40:0]        lo_next;
  logic signed [43:0] hi_next;
  logic signed [59:0] prod, sh_q, q_w;
  logic signed [40:0] diff, sh_p, p_w;
  logic signed [25:0] p26;
  logic signed [22:0] p_sat;
  logic               clip;

  assign en6      = !v6 || out_ready;
  assign en5      = !v5 || en6;
  assign en4      = !v4 || en5;
  assign in_ready = en4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en4) v4 <= in_valid;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  // stage 4: partial products on the low 17 and high 19 bits of SENS
  always_comb begin
    lo_next = in_item.d1 * in_item.sens[16:0];
    hi_next = $signed({1'b0, in_item.d1}) * $signed(in_item.sens[35:17]);
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_lo   <= lo_next;
      s4_hi   <= hi_next;
      s4_off  <= in_item.off;
      s4_dt   <= in_item.dt;
      s4_temp <= in_item.temp;
    end
  end

  // stage 5: merge partials, divide by 2^21 toward zero
  always_comb begin
    prod = (60'(s4_hi) <<< 17) + $signed({19'b0, s4_lo});
    sh_q = prod >>> 21;
    q_w  = sh_q + {59'b0, prod[59] && (|prod[20:0])};
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_q    <= 40'(q_w);
      s5_off  <= s4_off;
      s5_dt   <= s4_dt;
      s5_temp <= s4_temp;
    end
  end

  // stage 6: subtract offset, divide by 2^15 toward zero, saturate
  always_comb begin
    diff = 41'(s5_q) - 41'(s5_off);
    sh_p = diff >>> 15;
    p_w  = sh_p + {40'b0, diff[40] && (|diff[14:0])};
    p26  = 26'(p_w);
    clip = 1'b1;
    if (p26 > P_MAX) begin
      p_sat = 23'(P_MAX);
    end else if (p26 < P_MIN) begin
      p_sat = 23'(P_MIN);
    end else begin
      p_sat = 23'(p26);
      clip  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      s6.temp     <= s5_temp;
      s6.pressure <= p_sat;
      s6.dt       <= s5_dt;
      s6.clipped  <= clip;
    end
  end

  assign out_valid = v6;
  assign out_item  = s6;

endmodule
